// ===== src/ehcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ehcd_pkg
// Shared types and codes for the elevator hall call dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ehcd_pkg;

    localparam int NUM_CARS_DEF = 10;
    localparam int CAR_W        = 4;
    localparam int FLOOR_W      = 4;
    localparam int DIR_W        = 2;
    localparam int TIER_W       = 3;

    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    localparam logic [TIER_W-1:0] TIER_NONE = 3'd0;
    localparam logic [TIER_W-1:0] TIER_1    = 3'd1;
    localparam logic [TIER_W-1:0] TIER_2    = 3'd2;
    localparam logic [TIER_W-1:0] TIER_3    = 3'd3;
    localparam logic [TIER_W-1:0] TIER_4    = 3'd4;
    localparam logic [TIER_W-1:0] TIER_5    = 3'd5;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 4'd1;

    typedef struct packed {
        logic               opcode;
        logic [CAR_W-1:0]   car_index;
        logic [FLOOR_W-1:0] car_floor_in;
        logic [DIR_W-1:0]   car_direction_in;
        logic [FLOOR_W-1:0] hall_floor;
        logic               up_call;
        logic               down_call;
    } cmd_word_t;

    typedef struct packed {
        logic             up_valid;
        logic [CAR_W-1:0] up_car;
        logic             down_valid;
        logic [CAR_W-1:0] down_car;
    } result_word_t;

    typedef struct packed {
        logic               found;
        logic [TIER_W-1:0]  tier;
        logic [FLOOR_W-1:0] floor;
        logic [CAR_W-1:0]   car;
    } cand_t;

    typedef struct packed {
        logic               valid;
        logic [FLOOR_W-1:0] hall_floor;
        logic               up_call;
        logic               down_call;
        cand_t              up;
        cand_t              dn;
    } token_t;

endpackage

`default_nettype wire

// ===== src/ehcd_cell.sv =====
// ----------------------------------------------------------------------------
// ehcd_cell
// One car slot: holds floor and direction, updates the running best
// candidate of the passing dispatch token and hands it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ehcd_cell
    import ehcd_pkg::*;
#(
    parameter int unsigned CELL_ID = 0
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [CAR_W-1:0]   wr_index,
    input  wire logic [FLOOR_W-1:0] wr_floor,
    input  wire logic [DIR_W-1:0]   wr_dir,
    input  wire token_t             tok_in,
    output token_t                  tok_out
);

    localparam logic [CAR_W-1:0] MY_CAR = CAR_W'(CELL_ID);

    logic [FLOOR_W-1:0] floor_reg;
    logic [DIR_W-1:0]   dir_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               wr_hit;

    logic               at_h;
    logic               below_h;
    logic               above_h;
    logic               st;
    logic               up;
    logic               dn;
    logic [TIER_W-1:0]  up_tier;
    logic [TIER_W-1:0]  dn_tier;
    logic               up_hi;
    logic               dn_hi;

    function automatic logic better(input cand_t c, input logic [TIER_W-1:0] t,
                                    input logic [FLOOR_W-1:0] f, input logic hi);
        logic r;
        if (t == TIER_NONE)
            r = 1'b0;
        else if (!c.found || t < c.tier)
            r = 1'b1;
        else if (t == c.tier)
            r = hi ? (f > c.floor) : (f < c.floor);
        else
            r = 1'b0;
        return r;
    endfunction

    assign wr_hit = wr_en && ({{(32-CAR_W){1'b0}}, wr_index} == 32'(CELL_ID));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= FLOOR_RESET;
            dir_reg   <= DIR_STOP;
        end
        else if (wr_hit)
        begin
            floor_reg <= wr_floor;
            dir_reg   <= wr_dir;
        end
    end

    always_comb
    begin
        at_h    = floor_reg == tok_in.hall_floor;
        below_h = floor_reg < tok_in.hall_floor;
        above_h = floor_reg > tok_in.hall_floor;
        st      = dir_reg == DIR_STOP;
        up      = dir_reg == DIR_UP;
        dn      = dir_reg == DIR_DOWN;

        priority if (at_h && up)            up_tier = TIER_1;
        else if (below_h && (up || st))     up_tier = TIER_2;
        else if (below_h && dn)             up_tier = TIER_3;
        else if (above_h && (dn || st))     up_tier = TIER_4;
        else if (above_h && up)             up_tier = TIER_5;
        else                                up_tier = TIER_NONE;

        priority if (at_h && dn)            dn_tier = TIER_1;
        else if (above_h && (dn || st))     dn_tier = TIER_2;
        else if (above_h && up)             dn_tier = TIER_3;
        else if (below_h && (up || st))     dn_tier = TIER_4;
        else if (below_h && dn)             dn_tier = TIER_5;
        else                                dn_tier = TIER_NONE;

        up_hi = (up_tier == TIER_2) || (up_tier == TIER_5);
        dn_hi = (dn_tier == TIER_3) || (dn_tier == TIER_4);

        tok_next = tok_in;
        if (better(tok_in.up, up_tier, floor_reg, up_hi))
        begin
            tok_next.up.found = 1'b1;
            tok_next.up.tier  = up_tier;
            tok_next.up.floor = floor_reg;
            tok_next.up.car   = MY_CAR;
        end
        if (better(tok_in.dn, dn_tier, floor_reg, dn_hi))
        begin
            tok_next.dn.found = 1'b1;
            tok_next.dn.tier  = dn_tier;
            tok_next.dn.floor = floor_reg;
            tok_next.dn.car   = MY_CAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== src/elevator_hall_call_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// elevator_hall_call_dispatcher_unit
// Hall call dispatcher: a row of car cells, one dispatch token sweeping it.
// ----------------------------------------------------------------------------
// Update word: written in the accepting cycle, busy stays low, no result.
// Dispatch word: done pulses, registered, once the token has passed the last
// car cell; the token visits one car cell per cycle. Next word accepted in
// the done cycle, so a dispatch is not taken while another is in the row.
// Reset: every car at floor 1, stopped; no token in flight.
`default_nettype none

module elevator_hall_call_dispatcher_unit
    import ehcd_pkg::*;
#(
    parameter int NUM_CARS = NUM_CARS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire cmd_word_t cmd,
    output logic           done,
    output result_word_t   result
);

    token_t              tok [NUM_CARS+1];
    logic [NUM_CARS-1:0] live;
    logic                accept;
    logic                wr_en;
    logic                done_reg;
    result_word_t        result_reg;
    result_word_t        result_next;

    assign accept = start && !busy;
    assign wr_en  = accept && (cmd.opcode == OP_UPDATE);

    always_comb
    begin
        tok[0]            = '0;
        tok[0].valid      = accept && (cmd.opcode == OP_DISPATCH);
        tok[0].hall_floor = cmd.hall_floor;
        tok[0].up_call    = cmd.up_call;
        tok[0].down_call  = cmd.down_call;
    end

    for (genvar i = 0; i < NUM_CARS; i++)
    begin : g_cell
        ehcd_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en),
            .wr_index (cmd.car_index),
            .wr_floor (cmd.car_floor_in),
            .wr_dir   (cmd.car_direction_in),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
        assign live[i] = tok[i+1].valid;
    end

    assign busy = |live;

    always_comb
    begin
        result_next.up_valid   = tok[NUM_CARS].up_call;
        result_next.up_car     = (tok[NUM_CARS].up_call && tok[NUM_CARS].up.found)
                                 ? tok[NUM_CARS].up.car : '0;
        result_next.down_valid = tok[NUM_CARS].down_call;
        result_next.down_car   = (tok[NUM_CARS].down_call && tok[NUM_CARS].dn.found)
                                 ? tok[NUM_CARS].dn.car : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tok[NUM_CARS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (tok[NUM_CARS].valid)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(live) <= 1)
        else $error("more than one dispatch word in the cell row");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while a dispatch is still in the row");

    a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_DISPATCH) |=> busy)
        else $error("accepted dispatch word did not enter the row");

    a_up_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.up_valid) |-> (result.up_car == '0))
        else $error("up car reported without an up request");

    a_down_none: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.down_valid) |-> (result.down_car == '0))
        else $error("down car reported without a down request");
`endif

endmodule

`default_nettype wire
